// ===== hdl/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
// No dependencies.
`default_nettype none

package ple_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned POS_W  = 9;
  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_READ    = 3'd2,
    OP_FIND    = 3'd3,
    OP_REVERSE = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/ple_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module ple_ram #(
  parameter int unsigned ADDR_W = 8,
  parameter int unsigned DATA_W = 32
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  localparam int unsigned Words = 1 << ADDR_W;

  logic [DATA_W-1:0] mem_q [Words];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/ple_ctrl.sv =====
// Operation sequencer: decodes a transaction, walks the entry store through
// read-modify-write steps, and registers the result. Uses ple_pkg.
`default_nettype none

module ple_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [2:0]                   op_i,
  input  wire logic [ple_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [ple_pkg::DATA_W-1:0] value_i,
  input  wire logic [ple_pkg::DATA_W-1:0]   rdata_i,
  output ple_pkg::mem_req_t                 mem_o,
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic signed [ple_pkg::DATA_W-1:0] value_out_o,
  output logic [ple_pkg::POS_W-1:0]         found_position_o,
  output logic [ple_pkg::CNT_W-1:0]         count_o
);

  localparam int unsigned IW = ple_pkg::IDX_W;
  localparam int unsigned CW = ple_pkg::CNT_W;
  localparam int unsigned PW = ple_pkg::POS_W;
  localparam int unsigned DW = ple_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_INSW   = 3'd2;
  localparam logic [2:0] S_RDWAIT = 3'd3;
  localparam logic [2:0] S_FIND   = 3'd4;
  localparam logic [2:0] S_REV1   = 3'd5;
  localparam logic [2:0] S_REV2   = 3'd6;
  localparam logic [2:0] S_REV3   = 3'd7;

  logic [2:0]             state_q, state_d;
  ple_pkg::op_e           op_q, op_d;
  logic [PW-1:0]          pos_q, pos_d;
  logic [DW-1:0]          val_q, val_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [IW-1:0]          src_q, src_d;
  logic [IW-1:0]          end_q, end_d;
  logic [IW-1:0]          pdst_q, pdst_d;
  logic                   iss_q, iss_d;
  logic                   pend_q, pend_d;
  logic                   up_q, up_d;
  logic [DW-1:0]          tmp_q, tmp_d;

  logic                   done_q;
  ple_pkg::status_e       status_q;
  logic [DW-1:0]          vout_q;
  logic [PW-1:0]          fpos_q;
  logic [CW-1:0]          cout_q;

  logic                   fin;
  ple_pkg::status_e       fin_st;
  logic [DW-1:0]          fin_val;
  logic [PW-1:0]          fin_fpos;

  logic [CW-1:0]          cnt_m1;
  logic [PW-1:0]          pos_m1;
  logic [CW-1:0]          slot;

  assign cnt_m1 = cnt_q - CW'(1);
  assign pos_m1 = position_i - PW'(1);

  always_comb begin
    if (cnt_q == '0 || position_i == PW'(1)) begin
      slot = '0;
    end else if (CW'(position_i) >= cnt_q + CW'(1)) begin
      slot = cnt_q;
    end else begin
      slot = CW'(pos_m1);
    end
  end

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    pos_d    = pos_q;
    val_d    = val_q;
    cnt_d    = cnt_q;
    src_d    = src_q;
    end_d    = end_q;
    pdst_d   = pdst_q;
    iss_d    = iss_q;
    pend_d   = pend_q;
    up_d     = up_q;
    tmp_d    = tmp_q;
    fin      = 1'b0;
    fin_st   = ple_pkg::ST_OK;
    fin_val  = '0;
    fin_fpos = '0;
    mem_o.we    = 1'b0;
    mem_o.waddr = pdst_q;
    mem_o.wdata = rdata_i;
    mem_o.raddr = src_q;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = ple_pkg::op_e'(op_i);
          pos_d = position_i;
          val_d = value_i;
          case (ple_pkg::op_e'(op_i))
            ple_pkg::OP_INSERT: begin
              if (position_i == '0) begin
                fin    = 1'b1;
                fin_st = ple_pkg::ST_BADPOS;
              end else if (cnt_q == CW'(ple_pkg::DEPTH)) begin
                fin    = 1'b1;
                fin_st = ple_pkg::ST_FULL;
              end else begin
                end_d = slot[IW-1:0];
                if (slot == cnt_q) begin
                  state_d = S_INSW;
                end else begin
                  src_d   = cnt_m1[IW-1:0];
                  iss_d   = 1'b1;
                  pend_d  = 1'b0;
                  up_d    = 1'b0;
                  state_d = S_SHIFT;
                end
              end
            end
            ple_pkg::OP_REMOVE, ple_pkg::OP_READ: begin
              if (cnt_q == '0) begin
                fin    = 1'b1;
                fin_st = ple_pkg::ST_EMPTY;
              end else if (position_i == '0 || CW'(position_i) > cnt_q) begin
                fin    = 1'b1;
                fin_st = ple_pkg::ST_BADPOS;
              end else begin
                mem_o.raddr = pos_m1[IW-1:0];
                state_d     = S_RDWAIT;
              end
            end
            ple_pkg::OP_FIND: begin
              if (cnt_q == '0) begin
                fin    = 1'b1;
                fin_st = ple_pkg::ST_NOTFOUND;
              end else begin
                src_d   = '0;
                end_d   = cnt_m1[IW-1:0];
                iss_d   = 1'b1;
                pend_d  = 1'b0;
                state_d = S_FIND;
              end
            end
            ple_pkg::OP_REVERSE: begin
              if (cnt_q > CW'(1)) begin
                mem_o.raddr = '0;
                src_d       = '0;
                end_d       = cnt_m1[IW-1:0];
                state_d     = S_REV1;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (iss_q) begin
          mem_o.raddr = src_q;
          pend_d      = 1'b1;
          pdst_d      = up_q ? src_q - IW'(1) : src_q + IW'(1);
          if (src_q == end_q) begin
            iss_d = 1'b0;
          end else begin
            src_d = up_q ? src_q + IW'(1) : src_q - IW'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          mem_o.we = 1'b1;
        end
        if (!iss_q && !pend_q) begin
          if (op_q == ple_pkg::OP_INSERT) begin
            state_d = S_INSW;
          end else begin
            fin     = 1'b1;
            fin_val = tmp_q;
            cnt_d   = cnt_m1;
            state_d = S_IDLE;
          end
        end
      end

      S_INSW: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = end_q;
        mem_o.wdata = val_q;
        cnt_d       = cnt_q + CW'(1);
        fin         = 1'b1;
        state_d     = S_IDLE;
      end

      S_RDWAIT: begin
        tmp_d = rdata_i;
        if (op_q == ple_pkg::OP_READ) begin
          fin     = 1'b1;
          fin_val = rdata_i;
          state_d = S_IDLE;
        end else if (CW'(pos_q) < cnt_q) begin
          src_d   = pos_q[IW-1:0];
          end_d   = cnt_m1[IW-1:0];
          up_d    = 1'b1;
          iss_d   = 1'b1;
          pend_d  = 1'b0;
          state_d = S_SHIFT;
        end else begin
          fin     = 1'b1;
          fin_val = rdata_i;
          cnt_d   = cnt_m1;
          state_d = S_IDLE;
        end
      end

      S_FIND: begin
        if (iss_q) begin
          mem_o.raddr = src_q;
          pend_d      = 1'b1;
          pdst_d      = src_q;
          if (src_q == end_q) begin
            iss_d = 1'b0;
          end else begin
            src_d = src_q + IW'(1);
          end
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          if (rdata_i == val_q) begin
            fin      = 1'b1;
            fin_fpos = PW'(pdst_q) + PW'(1);
            iss_d    = 1'b0;
            pend_d   = 1'b0;
            state_d  = S_IDLE;
          end else if (!iss_q) begin
            fin     = 1'b1;
            fin_st  = ple_pkg::ST_NOTFOUND;
            state_d = S_IDLE;
          end
        end
      end

      S_REV1: begin
        mem_o.raddr = end_q;
        tmp_d       = rdata_i;
        state_d     = S_REV2;
      end

      S_REV2: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = src_q;
        mem_o.wdata = rdata_i;
        state_d     = S_REV3;
      end

      S_REV3: begin
        mem_o.we    = 1'b1;
        mem_o.waddr = end_q;
        mem_o.wdata = tmp_q;
        src_d       = src_q + IW'(1);
        end_d       = end_q - IW'(1);
        if (CW'(src_q) + CW'(2) < CW'(end_q)) begin
          mem_o.raddr = src_q + IW'(1);
          state_d     = S_REV1;
        end else begin
          fin     = 1'b1;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      iss_q    <= 1'b0;
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
      status_q <= ple_pkg::ST_OK;
      vout_q   <= '0;
      fpos_q   <= '0;
      cout_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      iss_q   <= iss_d;
      pend_q  <= pend_d;
      done_q  <= fin;
      if (fin) begin
        status_q <= fin_st;
        vout_q   <= fin_val;
        fpos_q   <= fin_fpos;
        cout_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    val_q  <= val_d;
    src_q  <= src_d;
    end_q  <= end_d;
    pdst_q <= pdst_d;
    up_q   <= up_d;
    tmp_q  <= tmp_d;
  end

  assign busy_o           = (state_q != S_IDLE);
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign value_out_o      = vout_q;
  assign found_position_o = fpos_q;
  assign count_o          = cout_q;

endmodule

`default_nettype wire

// ===== hdl/positional_list_engine.sv =====
// Positional list engine top level: sequencer plus the entry store RAM.
// Error cases, unused ops and short reverses finish from idle. Read and remove pass
// a read-wait state; a remove not at the tail then shifts down. Insert shifts up,
// then writes (appending writes at once). Find scans up; reverse swaps pairs.
// One transaction at a time, bounded by the store's single read port. The receiver
// cannot stall. Reset clears the entry count; store contents stay undefined.
`default_nettype none

module positional_list_engine (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [2:0]                   op_i,
  input  wire logic [ple_pkg::POS_W-1:0]    position_i,
  input  wire logic signed [ple_pkg::DATA_W-1:0] value_i,
  output logic                              done_o,
  output logic [2:0]                        status_o,
  output logic signed [ple_pkg::DATA_W-1:0] value_out_o,
  output logic [ple_pkg::POS_W-1:0]         found_position_o,
  output logic [ple_pkg::CNT_W-1:0]         count_o
);

  ple_pkg::mem_req_t             mem_req;
  logic [ple_pkg::DATA_W-1:0]    rdata;

  ple_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_o           (busy),
    .op_i             (op_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .rdata_i          (rdata),
    .mem_o            (mem_req),
    .done_o           (done_o),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .found_position_o (found_position_o),
    .count_o          (count_o)
  );

  ple_ram #(
    .ADDR_W (ple_pkg::IDX_W),
    .DATA_W (ple_pkg::DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

endmodule

`default_nettype wire

// ===== hdl/ple_checker.sv =====
// Port-level checker for positional_list_engine, bound to the top level.
// Uses ple_pkg.
`default_nettype none

module ple_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [2:0]                  status_o,
  input wire logic [ple_pkg::DATA_W-1:0]  value_out_o,
  input wire logic [ple_pkg::POS_W-1:0]   found_position_o,
  input wire logic [ple_pkg::CNT_W-1:0]   count_o
);

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transaction neither busy nor done");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ple_pkg::ST_FULL) |->
      (count_o == ple_pkg::CNT_W'(ple_pkg::DEPTH)))
    else $error("full status with count below depth");

  a_found_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_position_o != '0) |->
      (status_o == ple_pkg::ST_OK && ple_pkg::CNT_W'(found_position_o) <= count_o))
    else $error("found position out of range");

  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && value_out_o != '0) |-> (status_o == ple_pkg::ST_OK))
    else $error("nonzero value on failed transaction");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .done_o           (done_o),
  .status_o         (status_o),
  .value_out_o      (value_out_o),
  .found_position_o (found_position_o),
  .count_o          (count_o)
);

`default_nettype wire

// ===== dv/positional_list_engine_tb.sv =====
// Self-checking testbench for positional_list_engine: a shadow list predicts every
// transaction and a clocked monitor compares each strobed result, field by field.
// Depends on ple_pkg and the positional_list_engine RTL.
`timescale 1ns / 100ps

module positional_list_engine_tb;

  localparam int unsigned POS_W  = ple_pkg::POS_W;
  localparam int unsigned DATA_W = ple_pkg::DATA_W;
  localparam int unsigned CNT_W  = ple_pkg::CNT_W;
  localparam int unsigned DEPTH  = ple_pkg::DEPTH;

  typedef struct packed {
    logic [2:0]        op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              hold;      // wait for all outstanding results first
    logic [6:0]        idle_pct;  // odds of an idle burst before this transaction
  } list_cmd_t;

  typedef struct packed {
    ple_pkg::status_e  status;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  fpos;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [2:0]               op_i = '0;
  logic [POS_W-1:0]         position_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     done_o;
  logic [2:0]               status_o;
  logic signed [DATA_W-1:0] value_out_o;
  logic [POS_W-1:0]         found_position_o;
  logic [CNT_W-1:0]         count_o;

  positional_list_engine dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .position_i       (position_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .value_out_o      (value_out_o),
    .found_position_o (found_position_o),
    .count_o          (count_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  list_cmd_t         cmd_backlog[$];
  list_result_t      awaited_results[$];
  logic [DATA_W-1:0] shadow_entries [DEPTH];
  int                shadow_len = 0;
  int                mismatches = 0;
  logic              took_cmd = 1'b0;
  int                idle_left = 0;
  list_result_t      oldest;
  list_result_t      predicted;

  // stimulus generation state
  int                gen_len = 0;
  int                phase_idle = 0;
  logic              hold_next = 1'b0;
  logic [DATA_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                                        32'h1, 32'h5a5a_a5a5, 32'h0000_8000, 32'hdead_0001};

  // Shadow list: applies one transaction and returns the result it must produce.
  task automatic apply_list_op(input logic [2:0] op, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] val, output list_result_t r);
    int                n;
    int                slot;
    int                k;
    logic [DATA_W-1:0] t;
    n = shadow_len;
    r.status = ple_pkg::ST_OK;
    r.value  = '0;
    r.fpos   = '0;
    case (ple_pkg::op_e'(op))
      ple_pkg::OP_INSERT: begin
        if (pos == 0) begin
          r.status = ple_pkg::ST_BADPOS;
        end else if (n >= DEPTH) begin
          r.status = ple_pkg::ST_FULL;
        end else begin
          if (n == 0 || pos == 1) slot = 0;
          else if (int'(pos) >= n + 1) slot = n;
          else slot = int'(pos) - 1;
          for (k = n; k > slot; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[slot] = val;
          shadow_len = n + 1;
        end
      end
      ple_pkg::OP_REMOVE, ple_pkg::OP_READ: begin
        if (n == 0) begin
          r.status = ple_pkg::ST_EMPTY;
        end else if (pos == 0 || int'(pos) > n) begin
          r.status = ple_pkg::ST_BADPOS;
        end else begin
          r.value = shadow_entries[pos-1];
          if (op == ple_pkg::OP_REMOVE) begin
            for (k = int'(pos) - 1; k < n - 1; k++) shadow_entries[k] = shadow_entries[k+1];
            shadow_len = n - 1;
          end
        end
      end
      ple_pkg::OP_FIND: begin
        r.status = ple_pkg::ST_NOTFOUND;
        for (k = 0; k < n; k++) begin
          if (r.status == ple_pkg::ST_NOTFOUND && shadow_entries[k] == val) begin
            r.status = ple_pkg::ST_OK;
            r.fpos   = POS_W'(k + 1);
          end
        end
      end
      ple_pkg::OP_REVERSE: begin
        for (k = 0; k < n / 2; k++) begin
          t = shadow_entries[k];
          shadow_entries[k] = shadow_entries[n-1-k];
          shadow_entries[n-1-k] = t;
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(shadow_len);
  endtask

  // Monitor: checks strobed results, records accepted transactions.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      took_cmd <= 1'b0;
    end else begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("result with nothing outstanding: status %0d count %0d", status_o, count_o);
          mismatches++;
        end else begin
          oldest = awaited_results.pop_front();
          if (status_o !== oldest.status) begin
            $error("status: expected %0d, got %0d", oldest.status, status_o);
            mismatches++;
          end
          if (value_out_o !== oldest.value) begin
            $error("value_out: expected %0d, got %0d", $signed(oldest.value), value_out_o);
            mismatches++;
          end
          if (found_position_o !== oldest.fpos) begin
            $error("found_position: expected %0d, got %0d", oldest.fpos, found_position_o);
            mismatches++;
          end
          if (count_o !== oldest.count) begin
            $error("count: expected %0d, got %0d", oldest.count, count_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        apply_list_op(op_i, position_i, value_i, predicted);
        awaited_results.insert(awaited_results.size(), predicted);
        took_cmd <= 1'b1;
      end else begin
        took_cmd <= 1'b0;
      end
    end
  end

  // Driver: presents the backlog on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (took_cmd) begin
        cmd_backlog.delete(0);
        if (cmd_backlog.size() != 0 && $urandom_range(99) < cmd_backlog[0].idle_pct)
          idle_left = $urandom_range(10, 1);
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() != 0 &&
                   !(cmd_backlog[0].hold && awaited_results.size() != 0)) begin
        start      <= 1'b1;
        op_i       <= cmd_backlog[0].op;
        position_i <= cmd_backlog[0].pos;
        value_i    <= cmd_backlog[0].val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic add_cmd(input logic [2:0] op, input logic [POS_W-1:0] pos,
                         input logic [DATA_W-1:0] val);
    list_cmd_t c;
    c.op       = op;
    c.pos      = pos;
    c.val      = val;
    c.hold     = hold_next;
    c.idle_pct = 7'(phase_idle);
    hold_next  = 1'b0;
    cmd_backlog.insert(cmd_backlog.size(), c);
    if (op == ple_pkg::OP_INSERT && pos != 0 && gen_len < DEPTH) gen_len++;
    if (op == ple_pkg::OP_REMOVE && gen_len > 0 && pos != 0 && int'(pos) <= gen_len)
      gen_len--;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(1)) return value_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic logic [POS_W-1:0] pick_pos(input bit for_insert);
    int lim;
    int w;
    lim = gen_len + (for_insert ? 1 : 0);
    if (lim < 1) lim = 1;
    w = $urandom_range(99);
    if (w < 4) return '0;
    if (w < 12) return POS_W'($urandom_range(511));
    if (w < 22) return POS_W'(lim);
    if (w < 28) return POS_W'(1);
    return POS_W'($urandom_range(lim, 1));
  endfunction

  task automatic mixed_phase(input int n_items, input int idle);
    int         k;
    int         w;
    logic [2:0] op;
    phase_idle = idle;
    hold_next  = 1'b1;
    for (k = 0; k < n_items; k++) begin
      w = $urandom_range(99);
      if (w < (gen_len > 48 ? 24 : 34)) op = ple_pkg::OP_INSERT;
      else if (w < 58) op = ple_pkg::OP_REMOVE;
      else if (w < 74) op = ple_pkg::OP_READ;
      else if (w < 90) op = ple_pkg::OP_FIND;
      else if (w < 95) op = ple_pkg::OP_REVERSE;
      else op = 3'($urandom_range(7, 5));
      case (op)
        ple_pkg::OP_INSERT: add_cmd(op, pick_pos(1'b1), pick_value());
        ple_pkg::OP_REMOVE, ple_pkg::OP_READ: add_cmd(op, pick_pos(1'b0), $urandom());
        ple_pkg::OP_FIND: add_cmd(op, POS_W'($urandom_range(511)), pick_value());
        default: add_cmd(op, POS_W'($urandom_range(511)), $urandom());
      endcase
    end
  endtask

  // Fill to capacity, exercise the full list, then drain most of it.
  task automatic fill_phase();
    phase_idle = 10;
    hold_next  = 1'b1;
    while (gen_len < DEPTH) begin
      if ($urandom_range(99) < 85)
        add_cmd(ple_pkg::OP_INSERT, $urandom_range(1) ? POS_W'(257) : POS_W'(gen_len + 1),
                pick_value());
      else
        add_cmd(ple_pkg::OP_INSERT, POS_W'($urandom_range(gen_len > 0 ? gen_len : 1, 1)),
                pick_value());
    end
    add_cmd(ple_pkg::OP_INSERT, '0, pick_value());
    add_cmd(ple_pkg::OP_INSERT, POS_W'(1), pick_value());
    add_cmd(ple_pkg::OP_INSERT, POS_W'(300), pick_value());
    add_cmd(ple_pkg::OP_READ, POS_W'(256), $urandom());
    add_cmd(ple_pkg::OP_READ, POS_W'(257), $urandom());
    add_cmd(ple_pkg::OP_FIND, '0, value_pool[$urandom_range(7)]);
    add_cmd(ple_pkg::OP_FIND, '0, $urandom());
    add_cmd(ple_pkg::OP_REVERSE, POS_W'($urandom_range(511)), $urandom());
    add_cmd(ple_pkg::OP_READ, POS_W'(1), $urandom());
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(256), $urandom());
    add_cmd(ple_pkg::OP_INSERT, POS_W'(1), pick_value());
    add_cmd(ple_pkg::OP_INSERT, POS_W'(511), pick_value());
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(1), $urandom());
    while (gen_len > 8) begin
      if ($urandom_range(99) < 70) add_cmd(ple_pkg::OP_REMOVE, POS_W'(gen_len), $urandom());
      else add_cmd(ple_pkg::OP_REMOVE, POS_W'($urandom_range(gen_len, 1)), $urandom());
    end
  endtask

  initial begin
    // directed: empty list, error priorities, front/mid/append inserts, short reverses
    phase_idle = 20;
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_READ, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_FIND, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_REVERSE, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_INSERT, '0, 32'h1234_5678);
    add_cmd(ple_pkg::OP_INSERT, POS_W'(5), 32'h7fff_ffff);
    add_cmd(ple_pkg::OP_INSERT, POS_W'(1), 32'h8000_0000);
    add_cmd(ple_pkg::OP_INSERT, POS_W'(511), 32'h0);
    add_cmd(ple_pkg::OP_INSERT, POS_W'(2), 32'hffff_ffff);
    add_cmd(ple_pkg::OP_READ, '0, '0);
    add_cmd(ple_pkg::OP_READ, POS_W'(5), '0);
    add_cmd(ple_pkg::OP_READ, POS_W'(4), '0);
    add_cmd(ple_pkg::OP_FIND, '0, 32'h8000_0000);
    add_cmd(ple_pkg::OP_FIND, '0, 32'd12345);
    add_cmd(ple_pkg::OP_REVERSE, '0, '0);
    add_cmd(ple_pkg::OP_READ, POS_W'(1), '0);
    add_cmd(3'd5, POS_W'(3), 32'hffff_ffff);
    add_cmd(3'd6, POS_W'(511), 32'h0);
    add_cmd(3'd7, '0, 32'h8000_0000);
    add_cmd(ple_pkg::OP_REMOVE, '0, '0);
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(4), '0);
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_REVERSE, '0, '0);
    add_cmd(ple_pkg::OP_REMOVE, POS_W'(1), '0);
    add_cmd(ple_pkg::OP_REVERSE, '0, '0);

    mixed_phase(300, 20);
    mixed_phase(300, 0);
    fill_phase();
    mixed_phase(300, 50);
    mixed_phase(250, 10);
    mixed_phase(150, 0);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0 || awaited_results.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("positional_list_engine_tb passed");
    end else begin
      $display("positional_list_engine_tb failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("positional_list_engine_tb failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ple_pkg.sv
hdl/ple_ram.sv
hdl/ple_ctrl.sv
hdl/positional_list_engine.sv
hdl/ple_checker.sv
dv/positional_list_engine_tb.sv
